/* sv/assert_macros.svh */
// Assertion macros used by the port-level checker of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/lif_pkg.sv */
// Package with types, widths and register codes of the neuron update block.
package lif_pkg;

   // Default bank size
   localparam int NUM_NEURONS_DEF = 1024;

   // Field widths
   localparam int IDX_W    = 10;
   localparam int V_W      = 32;
   localparam int CNT_W    = 16;
   localparam int NOISE_W  = 16;
   localparam int DECAY_W  = 17;
   localparam int GAIN_W   = 32;
   localparam int CMP_W    = 17;
   localparam int CSR_IDX_W = 3;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 48;

   // Register indexes of the csr channel
   localparam logic [CSR_IDX_W-1:0] CSR_V_THRESH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_V_RESET    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_GAIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INPUT_GAIN = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_REFR_STEPS = 3'd6;

   // Decay of one (Q1.16) at reset
   localparam logic [DECAY_W-1:0] DECAY_ONE = 17'h10000;

   // Configuration seen by the datapath
   typedef struct packed {
      logic signed [V_W-1:0] v_thresh;
      logic signed [V_W-1:0] v_reset;
      logic signed [V_W-1:0] bias_current;
      logic signed [V_W-1:0] noise_gain;
      logic [DECAY_W-1:0]    decay_coeff;
      logic [GAIN_W-1:0]     input_gain;
      logic [CNT_W-1:0]      refractory_steps;
   } lif_cfg_type;

   // One input beat, unpacked
   typedef struct packed {
      logic [IDX_W-1:0]          neuron_index;
      logic signed [V_W-1:0]     syn_input;
      logic signed [NOISE_W-1:0] noise_sample;
   } lif_item_type;

   // Write-back request toward the state memories
   typedef struct packed {
      logic                  en;
      logic [IDX_W-1:0]      idx;
      logic signed [V_W-1:0] vm;
      logic [CNT_W-1:0]      cnt;
   } lif_wb_type;

   // Finished result toward the output register
   typedef struct packed {
      logic                  load;
      logic [IDX_W-1:0]      out_index;
      logic                  spiked;
      logic signed [V_W-1:0] membrane;
      logic                  refractory;
   } lif_rsp_type;

endpackage

/* sv/lif_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module lif_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/lif_csr.sv */
// Configuration register file of the neuron update block.
module lif_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [lif_pkg::CSR_IDX_W-1:0]    wr_index,
   input  logic [31:0]                      wr_data,
   output lif_pkg::lif_cfg_type             cfg
);
   import lif_pkg::*;

   lif_cfg_type cfg_ff;
   lif_cfg_type cfg_in;

   // Decode the register index
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_V_THRESH:   cfg_in.v_thresh         = wr_data;
            CSR_V_RESET:    cfg_in.v_reset          = wr_data;
            CSR_BIAS:       cfg_in.bias_current     = wr_data;
            CSR_NOISE_GAIN: cfg_in.noise_gain       = wr_data;
            CSR_DECAY:      cfg_in.decay_coeff      = wr_data[DECAY_W-1:0];
            CSR_INPUT_GAIN: cfg_in.input_gain       = wr_data;
            CSR_REFR_STEPS: cfg_in.refractory_steps = wr_data[CNT_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.v_thresh         <= '0;
         cfg_ff.v_reset          <= '0;
         cfg_ff.bias_current     <= '0;
         cfg_ff.noise_gain       <= '0;
         cfg_ff.decay_coeff      <= DECAY_ONE;
         cfg_ff.input_gain       <= '0;
         cfg_ff.refractory_steps <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* sv/lif_core.sv */
// Step datapath: decide, multiply, combine and write back one neuron.
module lif_core #(
   parameter int NUM_NEURONS = lif_pkg::NUM_NEURONS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lif_pkg::lif_cfg_type              cfg,
   input  logic                              start,
   input  lif_pkg::lif_item_type             item,
   input  logic signed [lif_pkg::V_W-1:0]    rd_vm,
   input  logic [lif_pkg::CNT_W-1:0]         rd_cnt,
   input  logic                              out_free,
   output logic                              busy,
   output lif_pkg::lif_wb_type               wb,
   output lif_pkg::lif_rsp_type              rsp
);
   import lif_pkg::*;

   // Phases of one item
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_READ = 2'd1;
   localparam logic [1:0] PH_MUL  = 2'd2;
   localparam logic [1:0] PH_DONE = 2'd3;

   // Kind of step taken
   localparam logic [1:0] KIND_INTEG = 2'd0;
   localparam logic [1:0] KIND_REFR  = 2'd1;
   localparam logic [1:0] KIND_FIRE  = 2'd2;

   localparam logic [CMP_W-1:0] NUM_CMP = CMP_W'(NUM_NEURONS);

   logic [1:0]                phase_ff, phase_in;
   logic [IDX_W-1:0]          idx_ff;
   logic                      inr_ff;
   logic signed [V_W-1:0]     syn_ff;
   logic signed [NOISE_W-1:0] noise_ff;
   logic signed [V_W-1:0]     vm_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic [1:0]                kind_ff, kind_in;
   logic signed [47:0]        noise_prod_ff;
   logic signed [49:0]        decay_prod_ff;
   logic signed [64:0]        drive_prod_ff;

   logic signed [V_W-1:0]     current;
   logic signed [49:0]        sum;
   logic signed [V_W-1:0]     sat_v;
   logic signed [V_W-1:0]     vm_new;
   logic [CNT_W-1:0]          cnt_new;
   logic                      finish;

   // Advance the phase; hold the last phase until the output register frees
   assign finish = (phase_ff == PH_DONE) && out_free;

   always_comb begin
      unique case (phase_ff)
         PH_IDLE: phase_in = start ? PH_READ : PH_IDLE;
         PH_READ: phase_in = PH_MUL;
         PH_MUL:  phase_in = PH_DONE;
         PH_DONE: phase_in = out_free ? PH_IDLE : PH_DONE;
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   assign busy = (phase_ff != PH_IDLE);

   // Latch the item on accept
   always_ff @(posedge clock) begin
      if (start && (phase_ff == PH_IDLE)) begin
         idx_ff   <= item.neuron_index;
         inr_ff   <= ({{(CMP_W-IDX_W){1'b0}}, item.neuron_index} < NUM_CMP);
         syn_ff   <= item.syn_input;
         noise_ff <= item.noise_sample;
      end
   end

   // Pick the step kind from the stored state
   always_comb begin
      if (rd_cnt != '0) begin
         kind_in = KIND_REFR;
      end else if (rd_vm >= cfg.v_thresh) begin
         kind_in = KIND_FIRE;
      end else begin
         kind_in = KIND_INTEG;
      end
   end

   // Read phase: capture state, kind and the noise product
   always_ff @(posedge clock) begin
      if (phase_ff == PH_READ) begin
         vm_ff         <= rd_vm;
         cnt_ff        <= rd_cnt;
         kind_ff       <= kind_in;
         noise_prod_ff <= noise_ff * cfg.noise_gain;
      end
   end

   // Multiply phase: sum the current, form decay and drive products
   assign current = syn_ff + cfg.bias_current + noise_prod_ff[43:12];

   always_ff @(posedge clock) begin
      if (phase_ff == PH_MUL) begin
         decay_prod_ff <= $signed({1'b0, cfg.decay_coeff}) * vm_ff;
         drive_prod_ff <= $signed({1'b0, cfg.input_gain}) * current;
      end
   end

   // Combine the floored terms and saturate
   assign sum = {{16{decay_prod_ff[49]}}, decay_prod_ff[49:16]}
              + {drive_prod_ff[64], drive_prod_ff[64:16]};

   always_comb begin
      if (sum[49:31] != {19{sum[49]}}) begin
         sat_v = sum[49] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         sat_v = sum[31:0];
      end
   end

   always_comb begin
      unique case (kind_ff)
         KIND_REFR: begin
            vm_new  = vm_ff;
            cnt_new = cnt_ff - 1'b1;
         end
         KIND_FIRE: begin
            vm_new  = cfg.v_reset;
            cnt_new = cfg.refractory_steps;
         end
         default: begin
            vm_new  = sat_v;
            cnt_new = '0;
         end
      endcase
   end

   // Write back and hand over the result
   always_comb begin
      wb.en  = finish && inr_ff;
      wb.idx = idx_ff;
      wb.vm  = vm_new;
      wb.cnt = cnt_new;

      rsp.load       = finish;
      rsp.out_index  = idx_ff;
      rsp.spiked     = inr_ff && (kind_ff == KIND_FIRE);
      rsp.membrane   = inr_ff ? vm_new : '0;
      rsp.refractory = inr_ff && (cnt_new != '0);
   end

endmodule

/* sv/lif_neuron_update.sv */
// Top level of the leaky integrate-and-fire neuron update block.
//
//   channel | dir | handshake            | payload
//   req     | in  | req_tvalid/tready    | tdata: neuron_index, syn_input, noise_sample
//   rsp     | out | rsp_tvalid/tready    | tdata: out_index, spiked, membrane, refractory
//   csr     | in  | csr_valid/csr_ready  | csr_index, csr_wdata
//
// An item passes through accept with memory read, decide and noise multiply, decay and drive
// multiply, then combine with write-back into the memories and the output register.
// One item is in flight; the read-modify-write of the state memories sets the rate.
// After reset a sweep clears both memories, with req_tready low until it ends.
// A waiting result sits in the output register; the next item is still accepted,
// and only the final step holds while that register is full and not taken.
module lif_neuron_update #(
   parameter int NUM_NEURONS = lif_pkg::NUM_NEURONS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // neuron_index [9:0], syn_input [41:10], noise_sample [57:42], zero [63:58]
   input  logic [lif_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // out_index [9:0], spiked [10], membrane [42:11], refractory [43], zero [47:44]
   output logic [lif_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lif_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [31:0]                         csr_wdata
);
   import lif_pkg::*;

   localparam int AW = (NUM_NEURONS > 1) ? $clog2(NUM_NEURONS) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_NEURONS - 1);

   lif_cfg_type  cfg;
   lif_item_type item;
   lif_wb_type   wb;
   lif_rsp_type  rsp;

   logic          accept;
   logic          busy;
   logic          out_free;
   logic          clear_ff, clear_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [V_W-1:0]   wr_vm;
   logic [CNT_W-1:0] wr_cnt;
   logic [V_W-1:0]   rd_vm;
   logic [CNT_W-1:0] rd_cnt;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   // Configuration registers, always ready
   assign csr_ready = 1'b1;

   lif_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   // Unpack the input beat
   assign item.neuron_index = req_tdata[9:0];
   assign item.syn_input    = req_tdata[41:10];
   assign item.noise_sample = req_tdata[57:42];

   assign req_tready = !clear_ff && !busy;
   assign accept     = req_tvalid && req_tready;

   // Clearing sweep after reset
   always_comb begin
      clear_in    = clear_ff;
      clr_addr_in = clr_addr_ff;
      if (clear_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == LAST_ADDR) begin
            clear_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff    <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clear_ff    <= clear_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Memory write port: sweep or write-back
   assign wr_en   = clear_ff || wb.en;
   assign wr_addr = clear_ff ? clr_addr_ff : AW'(wb.idx);
   assign wr_vm   = clear_ff ? '0 : wb.vm;
   assign wr_cnt  = clear_ff ? '0 : wb.cnt;

   lif_ram #(
      .WIDTH (V_W),
      .DEPTH (NUM_NEURONS),
      .AW    (AW)
   ) u_membrane_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_vm),
      .rd_en   (accept),
      .rd_addr (AW'(item.neuron_index)),
      .rd_data (rd_vm)
   );

   lif_ram #(
      .WIDTH (CNT_W),
      .DEPTH (NUM_NEURONS),
      .AW    (AW)
   ) u_refr_count_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_cnt),
      .rd_en   (accept),
      .rd_addr (AW'(item.neuron_index)),
      .rd_data (rd_cnt)
   );

   // Step datapath
   lif_core #(
      .NUM_NEURONS (NUM_NEURONS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .start    (accept),
      .item     (item),
      .rd_vm    ($signed(rd_vm)),
      .rd_cnt   (rd_cnt),
      .out_free (out_free),
      .busy     (busy),
      .wb       (wb),
      .rsp      (rsp)
   );

   // Output register
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp.load) begin
         rsp_data_ff <= {4'b0, rsp.refractory, rsp.membrane, rsp.spiked, rsp.out_index};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* sv/lif_checker.sv */
// Port-level checker of the neuron update block and its bind.
`include "assert_macros.svh"

module lif_checker #(
   parameter int NUM_NEURONS = lif_pkg::NUM_NEURONS_DEF
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [lif_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready
);
   import lif_pkg::*;

   localparam logic [CMP_W-1:0] NUM_CMP = CMP_W'(NUM_NEURONS);

   logic out_of_bank;
   logic req_beat;

   assign out_of_bank = ({{(CMP_W-IDX_W){1'b0}}, rsp_tdata[9:0]} >= NUM_CMP);
   assign req_beat    = req_tvalid && req_tready;

   // No result shows right after reset
   `ASSERT_CLK_ALWAYS(a_rsp_idle_after_reset, clock,
      reset |=> !rsp_tvalid, "result valid right after reset")

   // One item in flight: no second accept on the next edge
   `ASSERT_CLK(a_one_in_flight, clock, reset,
      req_beat |=> !req_tready, "input accepted on two edges in a row")

   // An index beyond the bank reports zeros
   `ASSERT_CLK(a_out_of_bank_zero, clock, reset,
      rsp_tvalid && out_of_bank |-> rsp_tdata[43:10] == 34'd0,
      "out-of-bank result carries nonzero fields")

   // A stalled result holds its beat
   `ASSERT_CLK(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata),
      "stalled result changed")

endmodule

bind lif_neuron_update lif_checker #(.NUM_NEURONS(NUM_NEURONS)) u_lif_checker (.*);

/* tb/lif_update_checker.sv */
// Checker that predicts each neuron update of lif_neuron_update and compares the results.
`timescale 1ns / 1ps

module lif_update_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [lif_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [lif_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [lif_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]                    csr_wdata,
   output int                             updates_in_flight,
   output int                             mismatch_count
);
   import lif_pkg::*;

   typedef struct packed {
      logic [IDX_W-1:0]      out_index;
      logic                  spiked;
      logic signed [V_W-1:0] membrane;
      logic                  refractory;
   } neuron_update_type;

   localparam longint V_MAX = 64'sd2147483647;
   localparam longint V_MIN = -V_MAX - 1;

   lif_cfg_type           cfg;
   logic signed [V_W-1:0] membrane_copy [NUM_NEURONS_DEF];
   logic [CNT_W-1:0]      countdown_copy [NUM_NEURONS_DEF];
   neuron_update_type     expected_updates [$];
   lif_item_type          arriving;
   neuron_update_type     observed;
   neuron_update_type     predicted;

   // Leak and integrate: floor shifts, wrapped current, saturated voltage
   function automatic logic signed [V_W-1:0] integrate_voltage(
      input logic signed [V_W-1:0]     vm,
      input logic signed [V_W-1:0]     syn,
      input logic signed [NOISE_W-1:0] noise
   );
      longint                noise_term;
      longint                decay_term;
      longint                drive_term;
      longint                total;
      logic signed [V_W-1:0] current;
      noise_term = (longint'(noise) * longint'($signed(cfg.noise_gain))) >>> 12;
      current    = syn + cfg.bias_current + noise_term[V_W-1:0];
      decay_term = (longint'(cfg.decay_coeff) * longint'(vm)) >>> 16;
      drive_term = (longint'(cfg.input_gain) * longint'(current)) >>> 16;
      total      = decay_term + drive_term;
      if (total > V_MAX) return V_MAX[V_W-1:0];
      if (total < V_MIN) return V_MIN[V_W-1:0];
      return total[V_W-1:0];
   endfunction

   // Advance one neuron by one time step and report what it did
   function automatic neuron_update_type step_neuron(input lif_item_type item);
      neuron_update_type     upd;
      logic signed [V_W-1:0] vm;
      logic [CNT_W-1:0]      cnt;
      upd = '0;
      upd.out_index = item.neuron_index;
      // an index outside the bank leaves the state alone
      if (item.neuron_index >= NUM_NEURONS_DEF) return upd;
      vm  = membrane_copy[item.neuron_index];
      cnt = countdown_copy[item.neuron_index];
      if (cnt != '0) begin
         cnt = cnt - 1'b1;
      end else if ($signed(vm) >= $signed(cfg.v_thresh)) begin
         upd.spiked = 1'b1;
         cnt        = cfg.refractory_steps;
         vm         = cfg.v_reset;
      end else begin
         vm = integrate_voltage(vm, item.syn_input, item.noise_sample);
      end
      membrane_copy[item.neuron_index]  = vm;
      countdown_copy[item.neuron_index] = cnt;
      upd.membrane   = vm;
      upd.refractory = (cnt != '0);
      return upd;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg             = '0;
         cfg.decay_coeff = DECAY_ONE;
         for (int n = 0; n < NUM_NEURONS_DEF; n++) begin
            membrane_copy[n]  = '0;
            countdown_copy[n] = '0;
         end
         expected_updates.delete();
         mismatch_count = 0;
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_V_THRESH:   cfg.v_thresh         = csr_wdata;
               CSR_V_RESET:    cfg.v_reset          = csr_wdata;
               CSR_BIAS:       cfg.bias_current     = csr_wdata;
               CSR_NOISE_GAIN: cfg.noise_gain       = csr_wdata;
               CSR_DECAY:      cfg.decay_coeff      = csr_wdata[DECAY_W-1:0];
               CSR_INPUT_GAIN: cfg.input_gain       = csr_wdata[GAIN_W-1:0];
               CSR_REFR_STEPS: cfg.refractory_steps = csr_wdata[CNT_W-1:0];
               default: ;
            endcase
         end
         // compare a result beat with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            observed.out_index  = rsp_tdata[9:0];
            observed.spiked     = rsp_tdata[10];
            observed.membrane   = rsp_tdata[42:11];
            observed.refractory = rsp_tdata[43];
            if (expected_updates.size() == 0) begin
               $error("out_index: expected none, actual %0d", observed.out_index);
               mismatch_count++;
            end else begin
               predicted = expected_updates.pop_front();
               if (observed.out_index !== predicted.out_index) begin
                  $error("out_index: expected %0d, actual %0d",
                         predicted.out_index, observed.out_index);
                  mismatch_count++;
               end
               if (observed.spiked !== predicted.spiked) begin
                  $error("spiked: expected %0b, actual %0b (neuron %0d)",
                         predicted.spiked, observed.spiked, predicted.out_index);
                  mismatch_count++;
               end
               if (observed.membrane !== predicted.membrane) begin
                  $error("membrane: expected %h, actual %h (neuron %0d)",
                         predicted.membrane, observed.membrane, predicted.out_index);
                  mismatch_count++;
               end
               if (observed.refractory !== predicted.refractory) begin
                  $error("refractory: expected %0b, actual %0b (neuron %0d)",
                         predicted.refractory, observed.refractory, predicted.out_index);
                  mismatch_count++;
               end
            end
         end
         // predict each accepted input beat
         if (req_tvalid && req_tready) begin
            arriving.neuron_index = req_tdata[9:0];
            arriving.syn_input    = req_tdata[41:10];
            arriving.noise_sample = req_tdata[57:42];
            expected_updates.push_back(step_neuron(arriving));
         end
      end
      updates_in_flight = expected_updates.size();
   end

endmodule

/* tb/testbench.sv */
// Top of the lif_neuron_update testbench: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps

module testbench;
   import lif_pkg::*;

   localparam int RESET_CYCLES    = 12;
   // clearing sweep plus about 470 updates at a generous per-update budget
   localparam int CYCLE_LIMIT     = 200000;
   localparam int PHASE_COUNT     = 6;
   localparam int PHASE_ITEMS     = 75;
   localparam int ITEMS_PER_MODE  = 150;
   localparam int POOL_SIZE       = 6;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int DRAIN_CYCLES    = 16;

   logic                    clock;
   logic                    reset;
   logic [REQ_DATA_W-1:0]   req_tdata;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [31:0]             csr_wdata;

   int                      updates_in_flight;
   int                      mismatch_count;
   int                      tx_idle_pct;
   int                      rx_idle_pct;
   logic                    hold_off_request;
   logic                    hold_off_done;
   logic [IDX_W-1:0]        active_neurons [POOL_SIZE];

   lif_neuron_update dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   lif_update_checker update_checker (
      .clock             (clock),
      .reset             (reset),
      .req_tdata         (req_tdata),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .rsp_tdata         (rsp_tdata),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .updates_in_flight (updates_in_flight),
      .mismatch_count    (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Write one register; called at a falling edge, returns at one
   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic program_regs(
      input logic [31:0]        thresh,
      input logic [31:0]        v_after_spike,
      input logic [31:0]        bias,
      input logic [31:0]        noise_scale,
      input logic [DECAY_W-1:0] decay,
      input logic [GAIN_W-1:0]  gain,
      input logic [CNT_W-1:0]   refr
   );
      write_reg(CSR_V_THRESH, thresh);
      write_reg(CSR_V_RESET, v_after_spike);
      write_reg(CSR_BIAS, bias);
      write_reg(CSR_NOISE_GAIN, noise_scale);
      write_reg(CSR_DECAY, {15'b0, decay});
      write_reg(CSR_INPUT_GAIN, gain);
      write_reg(CSR_REFR_STEPS, {16'b0, refr});
   endtask

   // Offer one update beat after a random gap; valid stays high for a following beat
   task automatic send_update(input logic [IDX_W-1:0] idx, input logic [V_W-1:0] syn,
                              input logic [NOISE_W-1:0] noise);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      // zero pad, noise_sample, syn_input, neuron_index
      req_tdata  <= {6'b0, noise, syn, idx};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Drop valid and wait until every predicted update has come back
   task automatic drain_updates();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (updates_in_flight != 0);
   endtask

   // Receiver: random back-pressure, plus one long hold-off on request
   initial begin
      rsp_tready    = 1'b0;
      hold_off_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request && !hold_off_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
            hold_off_done = 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // Watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("lif_neuron_update regression: fail");
      $finish;
   end

   initial begin : stimulus
      logic [IDX_W-1:0]   idx;
      logic [V_W-1:0]     syn;
      logic [NOISE_W-1:0] noise;
      int                 issued;
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      csr_valid        = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      tx_idle_pct      = 0;
      rx_idle_pct      = 0;
      hold_off_request = 1'b0;
      issued           = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: threshold zero, so a resting neuron fires at once
      send_update(10'd0, 32'h7FFF_FFFF, 16'h7FFF);
      send_update(10'd1023, 32'h8000_0000, 16'h8000);
      drain_updates();

      // Decay above one, refractory period of two: integrate, fire, count down, integrate
      program_regs(32'h0100_0000, 32'hFF80_0000, 32'h0010_0000, 32'h0100_0000,
                   17'h1FFFF, 32'h0001_0000, 16'd2);
      for (int n = 0; n < 9; n++)
         send_update(10'd5, 32'h0080_0000, n[0] ? 16'h1000 : 16'hF000);
      send_update(10'd1023, 32'h7FFF_FFFF, 16'h7FFF);
      send_update(10'd0, 32'h8000_0000, 16'h8000);
      drain_updates();

      // Full gain, zero decay, no refractory period: saturate high, fire, saturate low
      program_regs(32'h0100_0000, 32'hFF80_0000, 32'h0, 32'h0, 17'h0, 32'hFFFF_FFFF, 16'd0);
      send_update(10'd7, 32'h7FFF_0000, 16'h0);
      send_update(10'd7, 32'h8000_0000, 16'h8000);
      send_update(10'd7, 32'h8000_0000, 16'h0);
      send_update(10'd7, 32'h7FFF_FFFF, 16'h7FFF);
      drain_updates();

      // Random phases, each with its own settings and working set of neurons
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            1: program_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                            17'h0, 32'hFFFF_FFFF, 16'd0);
            5: program_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                            DECAY_ONE, 32'h0, 16'hFFFF);
            default:
               program_regs(32'h0100_0000 + $urandom_range(32'h0100_0000),
                            -$urandom_range(32'h0080_0000),
                            $urandom_range(32'h0004_0000),
                            $urandom_range(32'h0020_0000) - 32'h0010_0000,
                            DECAY_W'($urandom_range(65536, 52000)),
                            $urandom_range(32'h0002_0000, 32'h0000_8000),
                            CNT_W'($urandom_range(4)));
         endcase
         for (int k = 0; k < POOL_SIZE; k++)
            active_neurons[k] = IDX_W'($urandom_range(NUM_NEURONS_DEF - 1));
         // hold the receiver off while the sender keeps offering
         if (p == 2)
            hold_off_request <= 1'b1;

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (issued < ITEMS_PER_MODE) begin
               tx_idle_pct = 33;
               rx_idle_pct = 47;
            end else if (issued < 2 * ITEMS_PER_MODE) begin
               tx_idle_pct = 47;
               rx_idle_pct = 33;
            end else begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
            // mostly repeated steps of a few neurons with moderate input, rest raw noise
            if ($urandom_range(99) < 75) begin
               idx   = active_neurons[$urandom_range(POOL_SIZE - 1)];
               syn   = $urandom_range(32'h00C0_0000) - 32'h0020_0000;
               noise = NOISE_W'($urandom);
            end else begin
               idx   = IDX_W'($urandom);
               syn   = $urandom;
               noise = NOISE_W'($urandom);
            end
            send_update(idx, syn, noise);
            issued++;
         end
         drain_updates();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && updates_in_flight == 0)
         $display("lif_neuron_update regression: pass");
      else
         $display("lif_neuron_update regression: fail");
      $finish;
   end

endmodule
